// ===== hw/rtl/alpd_pkg.sv =====
// shared types, constants and register map of the line pulse decoder
package alpd_pkg;

  localparam int NUM_DEVICES = 8;
  localparam int TIMER_W     = 24;
  localparam int ELAPSED_W   = 16;
  localparam int DEV_ID_W    = 3;
  localparam int SHIFT_W     = 9;
  localparam int BYTE_W      = 8;
  localparam int APB_ADDR_W  = 5;
  localparam int APB_DATA_W  = 32;

  localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};
  localparam logic [SHIFT_W-1:0] START_MARKER = SHIFT_W'(1);

  localparam logic [TIMER_W-1:0] RESET_LIMIT_INIT   = TIMER_W'(1040);
  localparam logic [TIMER_W-1:0] ATTENTION_MIN_INIT = TIMER_W'(560);
  localparam logic [TIMER_W-1:0] ONE_MAX_INIT       = TIMER_W'(50);
  localparam logic [TIMER_W-1:0] ZERO_MAX_INIT      = TIMER_W'(72);
  localparam logic [TIMER_W-1:0] SRQ_MIN_INIT       = TIMER_W'(291);
  localparam logic [TIMER_W-1:0] SRQ_MAX_INIT       = TIMER_W'(309);

  typedef enum logic [2:0] {
    REG_RESET_LIMIT   = 3'd0,
    REG_ATTENTION_MIN = 3'd1,
    REG_ONE_MAX       = 3'd2,
    REG_ZERO_MAX      = 3'd3,
    REG_SRQ_MIN       = 3'd4,
    REG_SRQ_MAX       = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_RESET     = 3'd1,
    EV_ATTENTION = 3'd2,
    EV_BIT1      = 3'd3,
    EV_BIT0      = 3'd4,
    EV_SRQ       = 3'd5,
    EV_UNKNOWN   = 3'd6
  } event_t;

  typedef enum logic {
    FUNC_TIME   = 1'b0,
    FUNC_DRIVER = 1'b1
  } func_t;

  typedef struct packed {
    logic [TIMER_W-1:0] reset_limit;
    logic [TIMER_W-1:0] attention_min;
    logic [TIMER_W-1:0] one_max;
    logic [TIMER_W-1:0] zero_max;
    logic [TIMER_W-1:0] srq_min;
    logic [TIMER_W-1:0] srq_max;
  } thresholds_t;

endpackage

// ===== hw/rtl/alpd_regs.sv =====
// apb register file holding the six pulse width thresholds
module alpd_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [alpd_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [alpd_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [alpd_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  output alpd_pkg::thresholds_t            thr
);
  import alpd_pkg::*;

  logic                write_en;
  logic [2:0]          reg_sel;
  logic [TIMER_W-1:0]  wr_val;
  logic [TIMER_W-1:0]  rd_val;

  assign pready   = 1'b1;
  assign write_en = psel && penable && pwrite && pready;
  assign reg_sel  = paddr[APB_ADDR_W-1:2];
  assign wr_val   = pwdata[TIMER_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      thr.reset_limit   <= RESET_LIMIT_INIT;
      thr.attention_min <= ATTENTION_MIN_INIT;
      thr.one_max       <= ONE_MAX_INIT;
      thr.zero_max      <= ZERO_MAX_INIT;
      thr.srq_min       <= SRQ_MIN_INIT;
      thr.srq_max       <= SRQ_MAX_INIT;
    end else if (write_en) begin
      unique case (reg_sel)
        REG_RESET_LIMIT:   thr.reset_limit   <= wr_val;
        REG_ATTENTION_MIN: thr.attention_min <= wr_val;
        REG_ONE_MAX:       thr.one_max       <= wr_val;
        REG_ZERO_MAX:      thr.zero_max      <= wr_val;
        REG_SRQ_MIN:       thr.srq_min       <= wr_val;
        REG_SRQ_MAX:       thr.srq_max       <= wr_val;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_RESET_LIMIT:   rd_val = thr.reset_limit;
      REG_ATTENTION_MIN: rd_val = thr.attention_min;
      REG_ONE_MAX:       rd_val = thr.one_max;
      REG_ZERO_MAX:      rd_val = thr.zero_max;
      REG_SRQ_MIN:       rd_val = thr.srq_min;
      REG_SRQ_MAX:       rd_val = thr.srq_max;
      default:           rd_val = '0;
    endcase
  end

  assign prdata = {{(APB_DATA_W-TIMER_W){1'b0}}, rd_val};

endmodule

// ===== hw/rtl/alpd_classify.sv =====
// sorts a measured low time against the thresholds into one bus event
module alpd_classify (
  input  logic [alpd_pkg::TIMER_W-1:0] low_time,
  input  alpd_pkg::thresholds_t        thr,
  output alpd_pkg::event_t             ev
);
  import alpd_pkg::*;

  // priority order decides when windows overlap
  always_comb begin
    if (low_time > thr.reset_limit) begin
      ev = EV_RESET;
    end else if (low_time >= thr.attention_min) begin
      ev = EV_ATTENTION;
    end else if (low_time < thr.one_max) begin
      ev = EV_BIT1;
    end else if (low_time < thr.zero_max) begin
      ev = EV_BIT0;
    end else if (low_time >= thr.srq_min && low_time <= thr.srq_max) begin
      ev = EV_SRQ;
    end else begin
      ev = EV_UNKNOWN;
    end
  end

endmodule

// ===== hw/rtl/adb_line_pulse_decoder.sv =====
// top level of the line pulse decoder: input register, decode step and result register
// a word accepted into the input register is decoded and its result loaded into the result register
// throughput: one word per cycle, with out_ready held high
// the input register and the result register stall together on out_ready
// reset (rst, synchronous): thresholds to defaults, drivers low, timer zero,
// shifter to the start marker, both pipeline registers empty
module adb_line_pulse_decoder (
  input  logic                              clk,
  input  logic                              rst,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              func,
  input  logic [alpd_pkg::ELAPSED_W-1:0]    elapsed,
  input  logic [alpd_pkg::DEV_ID_W-1:0]     dev_sel,
  input  logic                              level,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [2:0]                        event_code,
  output logic                              byte_valid,
  output logic [alpd_pkg::BYTE_W-1:0]       byte_value,
  output logic                              line_level,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [alpd_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [alpd_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [alpd_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import alpd_pkg::*;

  thresholds_t thr;

  // input register
  logic                  s1_valid;
  logic                  s1_func;
  logic [ELAPSED_W-1:0]  s1_elapsed;
  logic [DEV_ID_W-1:0]   s1_dev_sel;
  logic                  s1_level;

  // decoder state
  logic [NUM_DEVICES-1:0] driver_bits, driver_bits_next;
  logic                   bus_level, bus_level_next;
  logic [TIMER_W-1:0]     low_timer, low_timer_next;
  logic [SHIFT_W-1:0]     bit_shifter, bit_shifter_next;

  logic                  out_load;
  logic                  s1_fire;
  logic                  dev_ok;
  logic [NUM_DEVICES-1:0] drv_upd;
  logic                  new_level;
  logic                  level_change;
  logic [TIMER_W:0]      timer_sum;
  logic [SHIFT_W-1:0]    shifted;
  event_t                cls_ev;
  event_t                ev;
  logic                  bv;
  logic [BYTE_W-1:0]     bval;

  alpd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .thr     (thr)
  );

  alpd_classify u_classify (
    .low_time (low_timer),
    .thr      (thr),
    .ev       (cls_ev)
  );

  // the result register frees up when empty or being taken this cycle
  assign out_load = !out_valid || out_ready;
  assign s1_fire  = s1_valid && out_load;
  assign in_ready = !s1_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_func    <= func;
      s1_elapsed <= elapsed;
      s1_dev_sel <= dev_sel;
      s1_level   <= level;
    end
  end

  // driver update: ids past the last device leave the line alone
  assign dev_ok = int'(s1_dev_sel) < NUM_DEVICES;

  always_comb begin
    drv_upd = driver_bits;
    for (int i = 0; i < NUM_DEVICES; i++) begin
      if (int'(s1_dev_sel) == i) begin
        drv_upd[i] = s1_level;
      end
    end
  end

  assign new_level    = &drv_upd;
  assign level_change = (s1_func == FUNC_DRIVER) && dev_ok && (new_level != bus_level);
  assign timer_sum    = {1'b0, low_timer} + {{(TIMER_W+1-ELAPSED_W){1'b0}}, s1_elapsed};
  assign shifted      = {bit_shifter[SHIFT_W-2:0], (cls_ev == EV_BIT1)};

  always_comb begin
    driver_bits_next = driver_bits;
    bus_level_next   = bus_level;
    low_timer_next   = low_timer;
    bit_shifter_next = bit_shifter;
    ev               = EV_NONE;
    bv               = 1'b0;
    bval             = '0;
    if (s1_func == FUNC_TIME) begin
      // saturating low-time count
      low_timer_next = timer_sum[TIMER_W] ? TIMER_MAX : timer_sum[TIMER_W-1:0];
    end else if (dev_ok) begin
      driver_bits_next = drv_upd;
      if (level_change) begin
        bus_level_next = new_level;
        low_timer_next = '0;
        // only a rising edge ends a low pulse worth decoding
        if (new_level) begin
          ev = cls_ev;
          case (cls_ev) inside
            EV_ATTENTION: bit_shifter_next = START_MARKER;
            EV_BIT1, EV_BIT0: begin
              if (shifted[SHIFT_W-1]) begin
                bv               = 1'b1;
                bval             = shifted[BYTE_W-1:0];
                bit_shifter_next = START_MARKER;
              end else begin
                bit_shifter_next = shifted;
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      driver_bits <= '0;
      bus_level   <= 1'b0;
      low_timer   <= '0;
      bit_shifter <= START_MARKER;
    end else if (s1_fire) begin
      driver_bits <= driver_bits_next;
      bus_level   <= bus_level_next;
      low_timer   <= low_timer_next;
      bit_shifter <= bit_shifter_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      event_code <= ev;
      byte_valid <= bv;
      byte_value <= bval;
      line_level <= bus_level_next;
    end
  end

  // a byte only completes on a shifted data bit
  a_byte_on_bit: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_valid |-> (event_code == EV_BIT1 || event_code == EV_BIT0))
    else $error("byte completed without a data bit");

  // any decoded event comes from a rising edge, so the line is high
  a_event_line_high: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_code != EV_NONE) |-> line_level)
    else $error("event reported with line low");

  // the marker never rests at the top of the shifter and never vanishes
  a_shifter_marker: assert property (@(posedge clk) disable iff (rst)
    !bit_shifter[SHIFT_W-1] && (bit_shifter != '0))
    else $error("shifter lost its start marker");

  // a stalled result register keeps the decoder state frozen
  a_stall_holds_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(low_timer) && $stable(bit_shifter))
    else $error("state moved while the result stalled");

endmodule
